// ===== hdl/mdve_pkg.sv =====
package mdve_pkg;

  // Number of coordinate lanes kept in history (2..4)
  localparam int LANES      = 3;
  localparam int LANE_IDX_W = (LANES > 2) ? 2 : 1;
  // Width used to compare a 2-bit lane code against the lane count
  localparam int LANE_CMP_W = 3;

  localparam int COORD_W = 16;
  localparam int INDEX_W = 16;
  localparam int MARK_W  = 17;
  // Raw code word before truncation: covers zigzag and face deltas
  localparam int WORD_W  = 18;
  // Bits actually coded
  localparam int CODE_W  = 15;

  localparam logic [7:0] CONT_BIT  = 8'h80;
  localparam logic [6:0] LOW7_MASK = 7'h7f;

  typedef enum logic {
    OP_COORD = 1'b0,
    OP_FACE  = 1'b1
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [1:0]          lane;
    logic [COORD_W-1:0]  coord_value;
    logic [INDEX_W-1:0]  index_value;
    logic                restart;
  } item_t;

  typedef struct packed {
    logic               overflow;
    logic [CODE_W-1:0]  code;
  } code_t;

endpackage

// ===== hdl/mdve_hist.sv =====
// Lane history and face high mark, plus the word mapping for one request.
// State is read and updated only for the request held in the input stage.
module mdve_hist
  import mdve_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  item_t  item,
  input  logic   commit,
  output code_t  result
);

  logic signed [COORD_W-1:0] lane_hist_r [LANES];
  logic signed [MARK_W-1:0]  high_mark_r;

  logic                      lane_ok;
  logic [LANE_IDX_W-1:0]     lane_idx;
  logic signed [COORD_W-1:0] prev;
  logic signed [COORD_W:0]   delta;
  logic signed [MARK_W-1:0]  mark_eff;
  logic signed [MARK_W-1:0]  index_ext;
  logic [WORD_W-1:0]         zz_word;
  logic [WORD_W-1:0]         face_word;
  logic [WORD_W-1:0]         word;

  // Lane lookup, restart makes history read as zero
  assign lane_ok  = LANE_CMP_W'(item.lane) < LANE_CMP_W'(LANES);
  assign lane_idx = item.lane[LANE_IDX_W-1:0];

  always_comb begin
    prev = '0;
    if (lane_ok && !item.restart) begin
      prev = lane_hist_r[lane_idx];
    end
  end

  // Coordinate: delta then zigzag
  assign delta   = $signed({item.coord_value[COORD_W-1], item.coord_value})
                 - $signed({prev[COORD_W-1], prev});
  assign zz_word = {delta, 1'b0} ^ {WORD_W{delta[COORD_W]}};

  // Face: mark + 1 - index, negative values overflow via top bit
  assign mark_eff  = item.restart ? '1 : high_mark_r;
  assign index_ext = $signed({1'b0, item.index_value});
  assign face_word = WORD_W'($signed({mark_eff[MARK_W-1], mark_eff})
                   + $signed(WORD_W'(1))
                   - $signed({2'b00, item.index_value}));

  always_comb begin
    case (item.op)
      OP_COORD: word = zz_word;
      OP_FACE:  word = face_word;
      default:  word = zz_word;
    endcase
  end

  assign result.overflow = |word[WORD_W-1:CODE_W];
  assign result.code     = word[CODE_W-1:0];

  // State update when the request leaves the input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LANES; i++) begin
        lane_hist_r[i] <= '0;
      end
      high_mark_r <= '1;
    end else if (commit) begin
      // Restart clears every lane unless this request rewrites it
      for (int i = 0; i < LANES; i++) begin
        if (item.op == OP_COORD && lane_ok && lane_idx == LANE_IDX_W'(i)) begin
          lane_hist_r[i] <= $signed(item.coord_value);
        end else if (item.restart) begin
          lane_hist_r[i] <= '0;
        end
      end
      if (item.op == OP_FACE && index_ext > mark_eff) begin
        high_mark_r <= index_ext;
      end else if (item.restart) begin
        high_mark_r <= '1;
      end
    end
  end

endmodule

// ===== hdl/mesh_delta_varint_encoder.sv =====
// Channel  Handshake           Payload
// in       in_valid/in_stall   in_op, in_lane, in_coord_value, in_index_value, in_restart
// out      out_valid/out_stall out_byte, out_last_byte, out_overflow
//
// A request whose code is below 0x80 leaves the output register as one byte
// and otherwise as two bytes; the output register gives one byte per cycle
// while out_stall is low. A request passes the input stage, then the output stage.
// Synchronous active-low reset: lanes go to zero, high mark to minus one.
// in_stall rises only while a request waits in the input stage and the
// output register still holds bytes of the previous request.
module mesh_delta_varint_encoder
  import mdve_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_op,
  input  logic [1:0]         in_lane,
  input  logic [COORD_W-1:0] in_coord_value,
  input  logic [INDEX_W-1:0] in_index_value,
  input  logic               in_restart,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_byte,
  output logic               out_last_byte,
  output logic               out_overflow
);

  // Input stage
  logic   s1_valid_r;
  item_t  s1_item_r;
  // Output stage
  logic              s2_valid_r;
  logic              s2_phase_r;
  code_t             s2_code_r;

  code_t  code;
  logic   in_fire;
  logic   out_fire;
  logic   out_done;
  logic   out_free;
  logic   s1_move;
  logic   two_byte;

  // Handshake control
  assign out_fire = s2_valid_r && !out_stall;
  assign out_done = out_fire && out_last_byte;
  assign out_free = !s2_valid_r || out_done;
  assign s1_move  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_fire  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_move) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r <= '{op:          op_t'(in_op),
                     lane:        in_lane,
                     coord_value: in_coord_value,
                     index_value: in_index_value,
                     restart:     in_restart};
    end
  end

  mdve_hist u_hist (
    .clk    (clk),
    .rst_n  (rst_n),
    .item   (s1_item_r),
    .commit (s1_move),
    .result (code)
  );

  // Output register and byte sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      s2_phase_r <= 1'b0;
    end else if (s1_move) begin
      s2_valid_r <= 1'b1;
      s2_phase_r <= 1'b0;
    end else if (out_done) begin
      s2_valid_r <= 1'b0;
      s2_phase_r <= 1'b0;
    end else if (out_fire) begin
      s2_phase_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_code_r <= code;
    end
  end

  assign two_byte      = |s2_code_r.code[CODE_W-1:7];
  assign out_valid     = s2_valid_r;
  assign out_last_byte = s2_phase_r || !two_byte;
  assign out_overflow  = s2_code_r.overflow;
  assign out_byte      = s2_phase_r ? s2_code_r.code[CODE_W-1:7]
                       : (two_byte ? (CONT_BIT | {1'b0, s2_code_r.code[6:0] & LOW7_MASK})
                                   : {1'b0, s2_code_r.code[6:0]});

`ifndef ASSERT_OFF
  // Second byte only for codes that need two
  a_phase_two_byte: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r && s2_phase_r |-> two_byte)
    else $error("second byte of a one-byte code");

  // A non-final byte always carries the continuation bit
  a_cont_bit: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r && !out_last_byte |-> out_byte[7])
    else $error("continuation bit missing");

  // After a first byte is taken the second byte follows
  a_second_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && !out_last_byte |=> s2_valid_r && s2_phase_r)
    else $error("second byte lost");

  // Input stalls only with a request waiting in the input stage
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && s2_valid_r)
    else $error("stall without a waiting request");
`endif

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

import mdve_pkg::*;

// One expected output byte of the variable length code
typedef struct packed {
  logic [7:0] data;
  logic       last;
  logic       ovf;
} code_byte_t;

// Tracks lane history and face high mark, predicts the byte code of every
// accepted request and checks the bytes that leave the block
class varint_scoreboard;
  int         lane_hist[LANES];
  int         high_mark;
  code_byte_t pending[$];
  int         errors;

  function new();
    errors = 0;
    clear_history();
  endfunction

  function void clear_history();
    foreach (lane_hist[i]) lane_hist[i] = 0;
    high_mark = -1;
  endfunction

  // Split a word into one or two code bytes
  function void push_word(logic [31:0] word);
    logic        ovf;
    logic [14:0] w15;
    code_byte_t  b;
    ovf = (word >= 32'h8000);
    w15 = word[14:0];
    if (w15 < 15'h80) begin
      b = '{data: w15[7:0], last: 1'b1, ovf: ovf};
      pending = {pending, b};
    end else begin
      b = '{data: CONT_BIT | {1'b0, w15[6:0]}, last: 1'b0, ovf: ovf};
      pending = {pending, b};
      b = '{data: w15[14:7], last: 1'b1, ovf: ovf};
      pending = {pending, b};
    end
  endfunction

  function void note_request(op_t op, logic [1:0] lane, logic [COORD_W-1:0] coord,
                             logic [INDEX_W-1:0] idx, logic restart);
    int          v;
    int          prev;
    int          d;
    int          idx_i;
    logic [31:0] word;
    if (restart) clear_history();
    if (op == OP_COORD) begin
      v = $signed(coord);
      prev = (lane < LANES) ? lane_hist[lane] : 0;
      d = v - prev;
      // zigzag: negative deltas map to odd words
      word = d <<< 1;
      if (d < 0) word = ~word;
      if (lane < LANES) lane_hist[lane] = v;
    end else begin
      idx_i = int'(idx);
      word = high_mark + 1 - idx_i;
      if (idx_i > high_mark) high_mark = idx_i;
    end
    push_word(word);
  endfunction

  function void check_byte(logic [7:0] data, logic last, logic ovf);
    code_byte_t exp_b;
    if (pending.size() == 0) begin
      $error("out_byte: no byte expected, got %0h", data);
      errors++;
      return;
    end
    exp_b = pending.pop_front();
    if (data !== exp_b.data) begin
      $error("out_byte: expected %0h, got %0h", exp_b.data, data);
      errors++;
    end
    if (last !== exp_b.last) begin
      $error("out_last_byte: expected %0b, got %0b", exp_b.last, last);
      errors++;
    end
    if (ovf !== exp_b.ovf) begin
      $error("out_overflow: expected %0b, got %0b", exp_b.ovf, ovf);
      errors++;
    end
  endfunction
endclass

module testbench;

  localparam int QUIET_LIMIT = 2000;
  localparam int PHASE_ITEMS = 225;

  logic               clk            = 1'b0;
  logic               rst_n          = 1'b0;
  logic               in_valid       = 1'b0;
  logic               in_stall;
  logic               in_op          = OP_COORD;
  logic [1:0]         in_lane        = '0;
  logic [COORD_W-1:0] in_coord_value = '0;
  logic [INDEX_W-1:0] in_index_value = '0;
  logic               in_restart     = 1'b0;
  logic               out_valid;
  logic               out_stall      = 1'b0;
  logic [7:0]         out_byte;
  logic               out_last_byte;
  logic               out_overflow;

  varint_scoreboard code_sb = new();

  int send_idle   = 0;
  int stall_pct   = 0;
  int quiet_count = 0;
  // stimulus-side shadow of lane values and mark, used only to shape items
  int gen_lane[4];
  int gen_mark;

  mesh_delta_varint_encoder dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_op          (in_op),
    .in_lane        (in_lane),
    .in_coord_value (in_coord_value),
    .in_index_value (in_index_value),
    .in_restart     (in_restart),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_last_byte  (out_last_byte),
    .out_overflow   (out_overflow)
  );

  always #4 clk = ~clk;

  // Random receiver back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Monitor both channels; quiet cycles feed the watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        code_sb.note_request(op_t'(in_op), in_lane, in_coord_value, in_index_value,
                             in_restart);
      if (out_valid && !out_stall)
        code_sb.check_byte(out_byte, out_last_byte, out_overflow);
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        quiet_count <= 0;
      else
        quiet_count <= quiet_count + 1;
    end
  end

  // Watchdog
  initial begin
    while (quiet_count < QUIET_LIMIT) @(posedge clk);
    $display("[FAIL] regression broken");
    $finish;
  end

  // Present one request and hold it until accepted
  task automatic send_item(input op_t op, input logic [1:0] lane,
                           input logic [COORD_W-1:0] coord,
                           input logic [INDEX_W-1:0] idx, input logic restart);
    if (restart) begin
      foreach (gen_lane[i]) gen_lane[i] = 0;
      gen_mark = -1;
    end
    if (op == OP_COORD && lane < LANES) gen_lane[lane] = $signed(coord);
    if (op == OP_FACE && int'(idx) > gen_mark) gen_mark = int'(idx);
    in_valid       <= 1'b1;
    in_op          <= op;
    in_lane        <= lane;
    in_coord_value <= coord;
    in_index_value <= idx;
    in_restart     <= restart;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic idle_gap();
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Wait until every predicted byte has left the block
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (code_sb.pending.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // Mostly mesh-like requests: small deltas and faces near the mark
  task automatic random_item();
    op_t              op;
    logic [1:0]       lane;
    logic [COORD_W-1:0] coord;
    logic [INDEX_W-1:0] idx;
    logic             restart;
    int               r;
    int               t;
    restart = ($urandom_range(99) < 3);
    if (restart) begin
      foreach (gen_lane[i]) gen_lane[i] = 0;
      gen_mark = -1;
    end
    op   = $urandom_range(1) ? OP_FACE : OP_COORD;
    lane = ($urandom_range(15) == 0) ? 2'd3 : 2'($urandom_range(LANES - 1));
    coord = 16'($urandom);
    idx   = 16'($urandom);
    if (op == OP_COORD) begin
      r = $urandom_range(9);
      if (r < 5)
        coord = 16'(gen_lane[lane] + int'($urandom_range(127)) - 64);
      else if (r < 8)
        coord = 16'(gen_lane[lane] + int'($urandom_range(16383)) - 8192);
    end else begin
      r = $urandom_range(9);
      if (r < 6)
        t = gen_mark + 1 - int'($urandom_range(200));
      else if (r < 8)
        t = gen_mark + 1 + int'($urandom_range(3));
      else
        t = -1;
      if (t >= 0 && t <= 65535) idx = 16'(t);
    end
    send_item(op, lane, coord, idx, restart);
  endtask

  initial begin
    foreach (gen_lane[i]) gen_lane[i] = 0;
    gen_mark = -1;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, one- and two-byte words, special cases
    send_item(OP_COORD, 2'd0, 16'h0000, 16'hffff, 1'b0);
    send_item(OP_COORD, 2'd0, 16'h7fff, 16'h0000, 1'b0); // overflow
    send_item(OP_COORD, 2'd0, 16'h8000, 16'hffff, 1'b0); // largest negative delta
    send_item(OP_COORD, 2'd1, 16'd63,   16'h0000, 1'b0);
    send_item(OP_COORD, 2'd1, 16'd64,   16'h0000, 1'b0);
    send_item(OP_COORD, 2'd1, 16'hffff, 16'h0000, 1'b0);
    send_item(OP_COORD, 2'd2, 16'd64,   16'h0000, 1'b0); // first two-byte word
    send_item(OP_COORD, 2'd3, 16'd100,  16'h0000, 1'b0); // lane out of range
    send_item(OP_COORD, 2'd3, 16'd101,  16'h0000, 1'b0);
    send_item(OP_FACE,  2'd0, 16'hffff, 16'd0,    1'b0);
    send_item(OP_FACE,  2'd3, 16'h0000, 16'd1,    1'b0);
    send_item(OP_FACE,  2'd0, 16'h0000, 16'd0,    1'b0);
    send_item(OP_FACE,  2'd0, 16'h0000, 16'hffff, 1'b0); // negative face word
    send_item(OP_FACE,  2'd0, 16'h0000, 16'd0,    1'b0); // word 2^16
    send_item(OP_FACE,  2'd0, 16'h0000, 16'd0,    1'b1); // restart
    send_item(OP_COORD, 2'd0, 16'd5,    16'h0000, 1'b1);
    send_item(OP_COORD, 2'd2, 16'd0,    16'h0000, 1'b0);
    send_item(OP_FACE,  2'd1, 16'h0000, 16'd32767, 1'b1);
    send_item(OP_FACE,  2'd0, 16'h0000, 16'd0,    1'b0); // word 2^15
    send_item(OP_FACE,  2'd0, 16'h0000, 16'd1,    1'b0); // word 2^15 - 1
    send_item(OP_FACE,  2'd0, 16'hffff, 16'hffff, 1'b0);
    drain();

    // Random phases with different idle and stall mixes
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin send_idle = 0;  stall_pct <= 0;  end
        1: begin send_idle = 62; stall_pct <= 0;  end
        2: begin send_idle = 0;  stall_pct <= 62; end
        default: begin send_idle = 8; stall_pct <= 8; end
      endcase
      repeat (PHASE_ITEMS) begin
        idle_gap();
        random_item();
      end
      drain();
    end

    repeat (8) @(posedge clk);
    if (code_sb.errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
